// ===== rtl/mtrr_pkg.sv =====
package mtrr_pkg;

  localparam int unsigned AddrW = 52;

  localparam logic [AddrW-1:0] OneMib  = AddrW'(64'h10_0000);
  localparam logic [AddrW:0]   PageOfs = (AddrW+1)'(4095);

  localparam logic ActWrite  = 1'b0;
  localparam logic ActLookup = 1'b1;

  localparam logic [2:0] TypeUc = 3'd0;
  localparam logic [2:0] TypeWt = 3'd4;
  localparam logic [2:0] TypeWb = 3'd6;

  localparam logic [1:0] StatOk       = 2'd0;
  localparam logic [1:0] StatNoFixed  = 2'd1;
  localparam logic [1:0] StatConflict = 2'd2;

  typedef struct packed {
    logic             action;
    logic [6:0]       entry_index;
    logic [AddrW-1:0] entry_start;
    logic [AddrW-1:0] entry_end;
    logic [2:0]       entry_type;
    logic             entry_invalid;
    logic [AddrW-1:0] page_address;
  } in_t;

  typedef struct packed {
    logic [2:0] mem_type;
    logic [1:0] status;
  } out_t;

  typedef struct packed {
    logic [AddrW-1:0] range_start;
    logic [AddrW-1:0] range_end;
    logic [2:0]       range_type;
  } entry_t;

  typedef struct packed {
    logic write;
    logic start;
    logic scan;
    logic publish;
  } cmd_t;

  typedef struct packed {
    logic done;
  } sts_t;

endpackage

// ===== rtl/mtrr_ram.sv =====
module mtrr_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/mtrr_ctrl.sv =====
module mtrr_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  input  logic           in_action_i,
  output logic           in_ready_o,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  output mtrr_pkg::cmd_t cmd_o,
  input  mtrr_pkg::sts_t sts_i
);

  import mtrr_pkg::*;

  typedef enum logic [1:0] {
    StIdle,
    StScan,
    StDone
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   accept;

  assign in_ready_o = (state_q == StIdle);
  assign accept     = in_valid_i && in_ready_o;

  always_comb begin
    cmd_o.write   = accept && (in_action_i == ActWrite);
    cmd_o.start   = accept && (in_action_i == ActLookup);
    cmd_o.scan    = (state_q == StScan);
    cmd_o.publish = (state_q == StDone) && (!out_valid_q || out_ready_i);
  end

  always_comb begin
    state_d     = state_q;
    out_valid_d = out_valid_q;
    if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
    case (state_q)
      StIdle: begin
        if (cmd_o.start) begin
          state_d = StScan;
        end
      end
      StScan: begin
        if (sts_i.done) begin
          state_d = StDone;
        end
      end
      StDone: begin
        if (cmd_o.publish) begin
          out_valid_d = 1'b1;
          state_d     = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

// ===== rtl/mtrr_dpath.sv =====
module mtrr_dpath #(
  parameter int unsigned FIXED_RANGES = 88,
  parameter int unsigned TOTAL_RANGES = 96
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  mtrr_pkg::in_t  in_data_i,
  input  mtrr_pkg::cmd_t cmd_i,
  output mtrr_pkg::sts_t sts_o,
  output mtrr_pkg::out_t out_data_o
);

  import mtrr_pkg::*;

  localparam int unsigned NFixed = (FIXED_RANGES < TOTAL_RANGES) ? FIXED_RANGES : TOTAL_RANGES;
  localparam int unsigned AW     = $clog2(TOTAL_RANGES);
  localparam int unsigned CW     = $clog2(TOTAL_RANGES + 1);
  localparam int unsigned EntryW = $bits(entry_t);

  logic [AddrW-1:0]  base_q;
  logic              low_q;
  logic [CW-1:0]     cnt_q, cnt_d;
  logic [CW-1:0]     end_q, end_d;
  logic              pend_q, pend_d;
  logic              off_r_q;
  logic              rec_q, rec_d;
  logic [2:0]        rec_type_q, rec_type_d;
  logic [TOTAL_RANGES-1:0] off_q;
  out_t              res_q, res_d;
  out_t              out_q;

  logic              wr_en;
  logic [AW-1:0]     wr_addr;
  logic              issue;
  logic              start_low;
  entry_t            wr_entry;
  entry_t            rd_entry;
  logic [EntryW-1:0] rd_raw;
  logic [AddrW:0]    last;
  logic              hit;
  logic              eval_done;
  logic              finish;

  assign wr_en   = cmd_i.write && (32'(in_data_i.entry_index) < 32'(TOTAL_RANGES));
  assign wr_addr = AW'(in_data_i.entry_index);
  assign issue   = cmd_i.scan && (cnt_q != end_q);

  assign start_low = (in_data_i.page_address < OneMib);

  always_comb begin
    wr_entry.range_start = in_data_i.entry_start;
    wr_entry.range_end   = in_data_i.entry_end;
    wr_entry.range_type  = in_data_i.entry_type;
  end

  mtrr_ram #(
    .WIDTH(EntryW),
    .DEPTH(TOTAL_RANGES)
  ) u_table (
    .clk_i  (clk_i),
    .we_i   (wr_en),
    .waddr_i(wr_addr),
    .wdata_i(wr_entry),
    .re_i   (issue),
    .raddr_i(cnt_q[AW-1:0]),
    .rdata_o(rd_raw)
  );

  assign rd_entry = rd_raw;
  assign last     = {1'b0, base_q} + PageOfs;
  assign hit      = (base_q >= rd_entry.range_start) && (last <= {1'b0, rd_entry.range_end});

  always_comb begin
    cnt_d      = cnt_q;
    end_d      = end_q;
    pend_d     = pend_q;
    rec_d      = rec_q;
    rec_type_d = rec_type_q;
    res_d      = res_q;
    eval_done  = 1'b0;
    finish     = 1'b0;

    if (cmd_i.start) begin
      cnt_d  = start_low ? '0 : CW'(NFixed);
      end_d  = start_low ? CW'(NFixed) : CW'(TOTAL_RANGES);
      pend_d = 1'b0;
      rec_d  = 1'b0;
    end else if (cmd_i.scan) begin
      pend_d = issue;
      if (issue) begin
        cnt_d = cnt_q + 1'b1;
      end
      if (pend_q) begin
        if (low_q) begin
          if (hit) begin
            eval_done      = 1'b1;
            res_d.mem_type = rd_entry.range_type;
            res_d.status   = StatOk;
          end
        end else if (hit && !off_r_q) begin
          if (rd_entry.range_type == TypeUc) begin
            rec_d      = 1'b1;
            rec_type_d = TypeUc;
          end else if (rd_entry.range_type == TypeWt && !(rec_q && rec_type_q == TypeUc)) begin
            rec_d      = 1'b1;
            rec_type_d = TypeWt;
          end else if (rec_q && (rec_type_q == TypeUc || rec_type_q == TypeWt)) begin
            rec_d = rec_q;
          end else if (!rec_q) begin
            rec_d      = 1'b1;
            rec_type_d = rd_entry.range_type;
          end else if (rec_type_q != rd_entry.range_type) begin
            eval_done      = 1'b1;
            res_d.mem_type = TypeUc;
            res_d.status   = StatConflict;
          end
        end
      end else if (cnt_q == end_q) begin
        finish = 1'b1;
        if (low_q) begin
          res_d.mem_type = TypeUc;
          res_d.status   = StatNoFixed;
        end else begin
          res_d.mem_type = (rec_q && rec_type_q == TypeUc) ? TypeUc : TypeWb;
          res_d.status   = StatOk;
        end
      end
    end
  end

  assign sts_o.done = eval_done || finish;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      end_q  <= '0;
      pend_q <= 1'b0;
      rec_q  <= 1'b0;
      low_q  <= 1'b0;
      off_q  <= '1;
    end else begin
      cnt_q  <= cnt_d;
      end_q  <= end_d;
      pend_q <= pend_d;
      rec_q  <= rec_d;
      if (cmd_i.start) begin
        low_q <= start_low;
      end
      if (wr_en) begin
        off_q[wr_addr] <= in_data_i.entry_invalid;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    rec_type_q <= rec_type_d;
    if (cmd_i.start) begin
      base_q <= in_data_i.page_address;
    end
    if (issue) begin
      off_r_q <= off_q[cnt_q[AW-1:0]];
    end
    if (sts_o.done) begin
      res_q <= res_d;
    end
    if (cmd_i.publish) begin
      out_q <= res_q;
    end
  end

  assign out_data_o = out_q;

endmodule

// ===== rtl/mtrr_memory_type_lookup_core.sv =====
// Memory type lookup over a table of TOTAL_RANGES address ranges; the first
// FIXED_RANGES slots are fixed ranges, the rest variable ranges. A write
// transaction loads one slot and gives no result; writes to slots at or
// beyond TOTAL_RANGES are dropped. A lookup transaction classifies one 4 KiB
// page and gives one result. The table sits in a single-port-read RAM read
// one slot per cycle; a lookup below 1 MiB scans the fixed slots and stops at
// the first match, and one at or above 1 MiB scans the variable slots and
// stops early on a conflict. One lookup is in flight at a time; a finished
// result waits in the output register while the next transaction is taken.
// Fixed slots must be written before lookups below 1 MiB are made; variable
// slots come out of reset marked invalid.
module mtrr_memory_type_lookup_core #(
  parameter int unsigned FIXED_RANGES = 88,
  parameter int unsigned TOTAL_RANGES = 96
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  mtrr_pkg::in_t  in_data_i,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  output mtrr_pkg::out_t out_data_o
);

  import mtrr_pkg::*;

  cmd_t cmd;
  sts_t sts;

  mtrr_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_action_i(in_data_i.action),
    .in_ready_o (in_ready_o),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .cmd_o      (cmd),
    .sts_i      (sts)
  );

  mtrr_dpath #(
    .FIXED_RANGES(FIXED_RANGES),
    .TOTAL_RANGES(TOTAL_RANGES)
  ) u_dpath (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_data_i (in_data_i),
    .cmd_i     (cmd),
    .sts_o     (sts),
    .out_data_o(out_data_o)
  );

  a_no_write_during_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.write |-> !cmd.scan)
    else $error("table write during scan");

  a_busy_after_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.start |=> !in_ready_o)
    else $error("input taken while lookup in progress");

  a_error_type_uc: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_data_o.status != StatOk) |-> out_data_o.mem_type == TypeUc)
    else $error("error result with non-uc type");

  a_publish_then_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.publish |=> out_valid_o)
    else $error("published result not presented");

endmodule
